@@ design/ltok_pkg.sv @@
// Shared types, constants and keyword tables of the line tokenizer.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package ltok_pkg;

    // Field widths of the character and token channels.
    localparam int CHAR_W         = 8;
    localparam int KIND_W         = 4;
    localparam int TOK_START_W    = 12;
    localparam int TOK_LEN_W      = 13;
    localparam int MAX_LINE_DEF   = 4096;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT     = 4'd0,
        KIND_FLOAT   = 4'd1,
        KIND_STRING  = 4'd2,
        KIND_PRINT   = 4'd3,
        KIND_NUMBER  = 4'd4,
        KIND_IDENT   = 4'd5,
        KIND_LITERAL = 4'd6,
        KIND_EQUALS  = 4'd7,
        KIND_PLUS    = 4'd8,
        KIND_MINUS   = 4'd9,
        KIND_SEMI    = 4'd10,
        KIND_EOL     = 4'd11
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [TOK_START_W-1:0] start;
        logic [TOK_LEN_W-1:0]   length;
        logic                   done;
        logic                   too_long;
    } token_t;

    localparam logic [CHAR_W-1:0] CHR_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHR_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;

    // Keywords in order int, float, string, print; unused places are zero.
    localparam int KW_NUM = 4;
    localparam logic [CHAR_W-1:0] KW_TEXT [KW_NUM][6] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00},
        '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67},
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd5, 3'd6, 3'd5};

    // Character of keyword k at place idx; zero beyond the table.
    function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k,
                                                  input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (idx < 3'd6)
        begin
            ch = KW_TEXT[k][idx];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/ltok_if.sv @@
// Valid/ready channel interfaces of the line tokenizer: characters in, tokens out.
// Depends on ltok_pkg for the field widths and the token kind type.
`timescale 1ns / 1ps
`default_nettype none

interface ltok_char_if;
    logic                        valid;
    logic                        ready;
    logic [ltok_pkg::CHAR_W-1:0] character;
    logic                        char_valid;
    logic                        line_last;

    modport source (output valid, character, char_valid, line_last, input ready);
    modport sink   (input valid, character, char_valid, line_last, output ready);
endinterface

interface ltok_token_if;
    logic                             valid;
    logic                             ready;
    ltok_pkg::kind_t                  token_kind;
    logic [ltok_pkg::TOK_START_W-1:0] token_start;
    logic [ltok_pkg::TOK_LEN_W-1:0]   token_length;
    logic                             line_done;
    logic                             too_long;

    modport source (output valid, token_kind, token_start, token_length, line_done,
                    too_long, input ready);
    modport sink   (input valid, token_kind, token_start, token_length, line_done,
                    too_long, output ready);
endinterface

`default_nettype wire

@@ design/line_tokenizer_core.sv @@
// Top level of the line tokenizer: line state, token formation and the token queue.
// Depends on ltok_pkg and on the channel interfaces in ltok_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// The core takes one character of a text line per transfer on the chars channel
// and reports tokens on the tokens channel as kind, start offset and length.
// Each character is handled entirely in the cycle in which it is accepted: the
// line state registers are updated and the up to three tokens it causes (a
// flushed word, an operator, the end-of-line token) are written together into a
// three-entry token register, which hands them out one per transfer in order.
// A new character is accepted whenever that register is empty or its last token
// leaves in the same cycle, so after a character that causes more than one token
// the next character is held while the token register drains, and a stall on the
// tokens channel holds it too. A character that causes no token adds no stall of
// its own. An item with
// line_last set flushes the pending word (unless inside an unterminated string
// literal, which is dropped), adds an end-of-line token with line_done set and
// returns all line state to its reset value. Offsets saturate at MAX_LINE-1 and
// lengths at MAX_LINE; too_long reports that the line went beyond MAX_LINE
// characters. There is no initialisation pass after reset.
module line_tokenizer_core #(
    parameter int MAX_LINE = ltok_pkg::MAX_LINE_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    ltok_char_if.sink    chars,
    ltok_token_if.source tokens
);
    import ltok_pkg::*;

    // Position counts up to MAX_LINE itself; offsets stay below MAX_LINE.
    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int OFF_W = $clog2(MAX_LINE);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);
    localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_LINE - 1);
    localparam int N_SLOT = 3;
    localparam int N_CAND = 4;

    // Line state.
    logic             in_literal_reg, in_literal_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [OFF_W-1:0] word_start_reg, word_start_next;
    logic [POS_W-1:0] word_length_reg, word_length_next;
    logic             number_ok_reg, number_ok_next;
    logic             dot_seen_reg, dot_seen_next;
    logic [KW_NUM-1:0] keyword_match_reg, keyword_match_next;
    logic             overflow_reg, overflow_next;

    // Token queue: entry 0 is the one on offer.
    token_t     slot_reg [N_SLOT];
    token_t     slot_next [N_SLOT];
    logic [1:0] count_reg, count_next;
    logic [1:0] new_count;

    logic       in_fire;
    logic       out_fire;

    token_t            cand [N_CAND];
    logic [N_CAND-1:0] cand_ok;

    // Offset of a position, saturated at MAX_LINE-1.
    function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W:0] p);
        logic [OFF_W-1:0] r;
        if (p >= {1'b0, MAX_POS})
        begin
            r = MAX_OFF;
        end
        else
        begin
            r = p[OFF_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] grow(input logic [POS_W-1:0] len);
        logic [POS_W-1:0] r;
        r = len;
        if (len < MAX_POS)
        begin
            r = len + POS_W'(1);
        end
        return r;
    endfunction

    // Keywords take priority over numbers, numbers over identifiers.
    function automatic kind_t classify(input logic [KW_NUM-1:0] kw,
                                       input logic [POS_W-1:0] len,
                                       input logic nok);
        kind_t r;
        r = nok ? KIND_NUMBER : KIND_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            if (kw[k] && len == POS_W'(KW_LEN[k]))
            begin
                r = kind_t'(k);
            end
        end
        return r;
    endfunction

    // Builds a token, fitting offset and length into the port widths.
    function automatic token_t make_tok(input kind_t kind,
                                        input logic [OFF_W-1:0] start,
                                        input logic [POS_W-1:0] len,
                                        input logic done,
                                        input logic ovf);
        token_t t;
        logic [OFF_W+TOK_START_W-1:0] s_wide;
        logic [POS_W+TOK_LEN_W-1:0]   l_wide;
        s_wide     = {{TOK_START_W{1'b0}}, start};
        l_wide     = {{TOK_LEN_W{1'b0}}, len};
        t.kind     = kind;
        t.start    = s_wide[TOK_START_W-1:0];
        t.length   = l_wide[TOK_LEN_W-1:0];
        t.done     = done;
        t.too_long = ovf;
        return t;
    endfunction

    assign chars.ready = (count_reg == 2'd0) || (count_reg == 2'd1 && tokens.ready);
    assign in_fire     = chars.valid && chars.ready;
    assign out_fire    = tokens.valid && tokens.ready;

    assign tokens.valid        = (count_reg != 2'd0);
    assign tokens.token_kind   = slot_reg[0].kind;
    assign tokens.token_start  = slot_reg[0].start;
    assign tokens.token_length = slot_reg[0].length;
    assign tokens.line_done    = slot_reg[0].done;
    assign tokens.too_long     = slot_reg[0].too_long;

    // Character decoding and line state update for one item.
    always_comb
    begin
        logic [CHAR_W-1:0] c;
        logic [OFF_W-1:0]  off;
        logic              is_space;
        logic              is_op;
        kind_t             op_kind;

        in_literal_next    = in_literal_reg;
        position_next      = position_reg;
        word_start_next    = word_start_reg;
        word_length_next   = word_length_reg;
        number_ok_next     = number_ok_reg;
        dot_seen_next      = dot_seen_reg;
        keyword_match_next = keyword_match_reg;
        overflow_next      = overflow_reg;
        cand_ok            = '0;
        for (int i = 0; i < N_CAND; i++)
        begin
            cand[i] = '0;
        end

        c        = chars.character;
        off      = sat_off({1'b0, position_reg});
        is_space = (c inside {[CHR_TAB:CHR_CR], CHR_SPACE});
        is_op    = 1'b1;
        case (c)
            CHR_EQ:    op_kind = KIND_EQUALS;
            CHR_PLUS:  op_kind = KIND_PLUS;
            CHR_MINUS: op_kind = KIND_MINUS;
            CHR_SEMI:  op_kind = KIND_SEMI;
            default:
            begin
                op_kind = KIND_EOL;
                is_op   = 1'b0;
            end
        endcase

        if (chars.char_valid)
        begin
            if (position_reg == MAX_POS)
            begin
                overflow_next = 1'b1;
            end

            if (c == CHR_QUOTE)
            begin
                if (!in_literal_reg)
                begin
                    // An opening quote drops any pending word.
                    in_literal_next    = 1'b1;
                    word_length_next   = '0;
                    keyword_match_next = '1;
                    number_ok_next     = 1'b1;
                    dot_seen_next      = 1'b0;
                    word_start_next    = sat_off({1'b0, position_reg} + (POS_W+1)'(1));
                end
                else
                begin
                    cand_ok[0] = 1'b1;
                    cand[0]    = make_tok(KIND_LITERAL, word_start_reg, word_length_reg,
                                          1'b0, overflow_next);
                    in_literal_next    = 1'b0;
                    word_length_next   = '0;
                    word_start_next    = '0;
                    keyword_match_next = '1;
                    number_ok_next     = 1'b1;
                    dot_seen_next      = 1'b0;
                end
            end
            else if (in_literal_reg)
            begin
                word_length_next = grow(word_length_reg);
            end
            else if (is_space || is_op)
            begin
                if (word_length_reg != '0)
                begin
                    cand_ok[0] = 1'b1;
                    cand[0]    = make_tok(classify(keyword_match_reg, word_length_reg,
                                                   number_ok_reg),
                                          word_start_reg, word_length_reg, 1'b0,
                                          overflow_next);
                    word_length_next   = '0;
                    word_start_next    = '0;
                    keyword_match_next = '1;
                    number_ok_next     = 1'b1;
                    dot_seen_next      = 1'b0;
                end
                if (is_op)
                begin
                    cand_ok[1] = 1'b1;
                    cand[1]    = make_tok(op_kind, off, POS_W'(1), 1'b0, overflow_next);
                end
            end
            else
            begin
                // A word character: a fresh word starts from clean flags.
                if (word_length_reg == '0)
                begin
                    keyword_match_next = '1;
                    number_ok_next     = 1'b1;
                    dot_seen_next      = 1'b0;
                    word_start_next    = off;
                end
                for (int k = 0; k < KW_NUM; k++)
                begin
                    if (!(word_length_reg < POS_W'(KW_LEN[k]) &&
                          c == kw_char(2'(k), word_length_reg[2:0])))
                    begin
                        keyword_match_next[k] = 1'b0;
                    end
                end
                if (c == CHR_DOT && !dot_seen_next)
                begin
                    dot_seen_next = 1'b1;
                end
                else if (c < CHR_ZERO || c > CHR_NINE)
                begin
                    number_ok_next = 1'b0;
                end
                word_length_next = grow(word_length_reg);
            end

            if (position_reg != MAX_POS)
            begin
                position_next = position_reg + POS_W'(1);
            end
        end

        if (chars.line_last)
        begin
            // A pending word is flushed unless an unterminated literal is open.
            if (!in_literal_next && word_length_next != '0)
            begin
                cand_ok[2] = 1'b1;
                cand[2]    = make_tok(classify(keyword_match_next, word_length_next,
                                               number_ok_next),
                                      word_start_next, word_length_next, 1'b0,
                                      overflow_next);
            end
            cand_ok[3] = 1'b1;
            cand[3]    = make_tok(KIND_EOL, sat_off({1'b0, position_next}), '0, 1'b1,
                                  overflow_next);
            in_literal_next    = 1'b0;
            position_next      = '0;
            word_start_next    = '0;
            word_length_next   = '0;
            number_ok_next     = 1'b1;
            dot_seen_next      = 1'b0;
            keyword_match_next = '1;
            overflow_next      = 1'b0;
        end
    end

    // Token queue: load the packed tokens of an accepted item, or shift one out.
    always_comb
    begin
        token_t     packed_tok [N_SLOT];
        logic [1:0] n;

        n = 2'd0;
        for (int i = 0; i < N_SLOT; i++)
        begin
            packed_tok[i] = '0;
        end
        for (int i = 0; i < N_CAND; i++)
        begin
            if (cand_ok[i] && n < 2'(N_SLOT))
            begin
                packed_tok[n] = cand[i];
                n = n + 2'd1;
            end
        end
        new_count = n;

        for (int i = 0; i < N_SLOT; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        count_next = count_reg;
        if (in_fire)
        begin
            for (int i = 0; i < N_SLOT; i++)
            begin
                slot_next[i] = packed_tok[i];
            end
            count_next = new_count;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < N_SLOT - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_literal_reg    <= 1'b0;
            position_reg      <= '0;
            word_start_reg    <= '0;
            word_length_reg   <= '0;
            number_ok_reg     <= 1'b1;
            dot_seen_reg      <= 1'b0;
            keyword_match_reg <= '1;
            overflow_reg      <= 1'b0;
            count_reg         <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                in_literal_reg    <= in_literal_next;
                position_reg      <= position_next;
                word_start_reg    <= word_start_next;
                word_length_reg   <= word_length_next;
                number_ok_reg     <= number_ok_next;
                dot_seen_reg      <= dot_seen_next;
                keyword_match_reg <= keyword_match_next;
                overflow_reg      <= overflow_next;
            end
            count_reg <= count_next;
        end
    end

    // Token payload needs no reset: it is only read while count_reg is non-zero.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_SLOT; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

`default_nettype wire
